>>> src/ccpu_pkg.sv
// Shared constants, types and the CRC byte update for the CRC-checked PCM16 unpacker.
package ccpu_pkg;

  localparam int unsigned CrcW          = 32;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned SampleW       = 16;
  localparam int unsigned SampleTotalW  = 31;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned CfgDataW      = 32;
  localparam int unsigned FifoDepthDflt = 4;

  localparam logic [CrcW-1:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] CrcPoly = 32'hEDB8_8320;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgExpectedCrc = 1'b0,
    CfgSampleTotal = 1'b1
  } cfg_reg_e;

  // One classified sample waiting between front and back
  typedef struct packed {
    logic [ByteW-1:0] low_byte;
    logic [ByteW-1:0] high_byte;
    logic             is_last;
    logic             crc_ok;
  } entry_t;

  // Reflected CRC-32, one byte, eight bit steps unrolled
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] data);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, data};
    for (int k = 0; k < ByteW; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : '0);
    end
    return c;
  endfunction

endpackage

>>> src/ccpu_if.sv
// Stream interfaces: payload bytes in, decoded samples out.
interface ccpu_byte_if;
  logic                            valid;
  logic                            ready;
  logic [ccpu_pkg::ByteW-1:0]      data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ccpu_sample_if;
  logic                              valid;
  logic                              ready;
  logic signed [ccpu_pkg::SampleW-1:0] sample_value;
  logic                              is_last;
  logic                              crc_ok;

  modport source (output valid, output sample_value, output is_last, output crc_ok,
                  input ready);
  modport sink   (input valid, input sample_value, input is_last, input crc_ok,
                  output ready);
endinterface

>>> src/crc_checked_pcm16_unpack_core.sv
// Top level of the CRC-checked PCM16 unpacker.
//
//   port       dir  payload                          per transaction
//   byte_i     in   data_byte[7:0]                   one payload byte
//   sample_o   out  sample_value[15:0] signed,       one sample per two bytes
//                   is_last, crc_ok
//   cfg_*      in   cfg_idx_i, cfg_wdata_i[31:0]     one register write
//
// Takes one byte per cycle while the sample queue has room; the per-byte CRC-32
// update and the sample count compare are combinational in the front end. A sample
// reaches sample_o through the queue write, then the registered queue read.
// Reset clears the CRC to all ones, the byte parity and sample count; no
// clearing pass. byte_i stalls only when the sample queue is full.
module crc_checked_pcm16_unpack_core #(
  parameter int unsigned FifoDepth = ccpu_pkg::FifoDepthDflt
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ccpu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ccpu_pkg::CfgDataW-1:0] cfg_wdata_i,
  ccpu_byte_if.sink                     byte_i,
  ccpu_sample_if.source                 sample_o
);

  logic             push, q_full, pop, head_valid;
  ccpu_pkg::entry_t entry, head;

  ccpu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_i      (byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (entry)
  );

  ccpu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  ccpu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .sample_o     (sample_o)
  );

endmodule

>>> src/ccpu_front.sv
// Front end: takes bytes, runs the CRC, pairs bytes and classifies each sample.
module ccpu_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ccpu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ccpu_pkg::CfgDataW-1:0] cfg_wdata_i,
  ccpu_byte_if.sink                     byte_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output ccpu_pkg::entry_t              entry_o
);

  logic [ccpu_pkg::CrcW-1:0]         expected_q;
  logic [ccpu_pkg::SampleTotalW-1:0] total_q;
  logic [ccpu_pkg::CrcW-1:0]         crc_q;
  logic                              odd_q;
  logic [ccpu_pkg::SampleTotalW-1:0] pair_cnt_q;
  logic [ccpu_pkg::ByteW-1:0]        low_q;

  logic                              accept;
  logic [ccpu_pkg::CrcW-1:0]         crc_d;
  logic [ccpu_pkg::SampleTotalW:0]   done;
  logic                              last;
  ccpu_pkg::cfg_reg_e                cfg_idx;

  assign byte_i.ready = !q_full_i;
  assign accept       = byte_i.valid && byte_i.ready;
  assign crc_d        = ccpu_pkg::crc_byte(crc_q, byte_i.data_byte);
  assign cfg_idx      = ccpu_pkg::cfg_reg_e'(cfg_idx_i);

  // Samples completed including this one; a zero total behaves as one
  assign done = {1'b0, pair_cnt_q} + {{ccpu_pkg::SampleTotalW{1'b0}}, 1'b1};
  assign last = done >= {1'b0, total_q};

  // A sample leaves on every second byte
  assign push_o            = accept && odd_q;
  assign entry_o.low_byte  = low_q;
  assign entry_o.high_byte = byte_i.data_byte;
  assign entry_o.is_last   = last;
  assign entry_o.crc_ok    = last && ((crc_d ^ ccpu_pkg::CrcInit) == expected_q);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= '0;
      total_q    <= ccpu_pkg::SampleTotalW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx)
        ccpu_pkg::CfgExpectedCrc: expected_q <= cfg_wdata_i;
        ccpu_pkg::CfgSampleTotal: total_q    <= cfg_wdata_i[ccpu_pkg::SampleTotalW-1:0];
        default: ;
      endcase
    end
  end

  // Load state: CRC, byte parity, sample count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= ccpu_pkg::CrcInit;
      odd_q      <= 1'b0;
      pair_cnt_q <= '0;
    end else if (accept) begin
      if (!odd_q) begin
        crc_q <= crc_d;
        odd_q <= 1'b1;
      end else if (last) begin
        crc_q      <= ccpu_pkg::CrcInit;
        odd_q      <= 1'b0;
        pair_cnt_q <= '0;
      end else begin
        crc_q      <= crc_d;
        odd_q      <= 1'b0;
        pair_cnt_q <= pair_cnt_q + ccpu_pkg::SampleTotalW'(1);
      end
    end
  end

  // Held low byte, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && !odd_q) begin
      low_q <= byte_i.data_byte;
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && entry_o.is_last |=> crc_q == ccpu_pkg::CrcInit && !odd_q && pair_cnt_q == '0)
    else $error("load state not restarted after last sample");

  a_ok_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && !entry_o.is_last |-> !entry_o.crc_ok)
    else $error("crc_ok set on a sample that is not last");

endmodule

>>> src/ccpu_fifo.sv
// Short queue of classified samples between front and back.
module ccpu_fifo #(
  parameter int unsigned Depth = ccpu_pkg::FifoDepthDflt
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ccpu_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output ccpu_pkg::entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ccpu_pkg::entry_t mem [Depth];
  ccpu_pkg::entry_t rd_data_q;
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  // head_o is the entry taken by the most recent pop
  assign head_o  = rd_data_q;

  // Storage write
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= entry_i;
    end
  end

  // Registered read of the oldest entry on pop
  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count out of range");

endmodule

>>> src/ccpu_back.sv
// Back end: builds the signed sample from the popped entry and tracks output valid.
module ccpu_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  ccpu_pkg::entry_t head_i,
  output logic             pop_o,
  ccpu_sample_if.source    sample_o
);

  logic out_valid_q;

  // Refill the output register when it is empty or being taken
  assign pop_o = head_valid_i && (!out_valid_q || sample_o.ready);

  // Low byte first: high byte in the upper half
  assign sample_o.valid        = out_valid_q;
  assign sample_o.sample_value = signed'({head_i.high_byte, head_i.low_byte});
  assign sample_o.is_last      = head_i.is_last;
  assign sample_o.crc_ok       = head_i.crc_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (sample_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

>>> dv/tb_crc_checked_pcm16_unpack_core.sv
// Testbench for the CRC-checked PCM16 unpacker: random payload loads checked against a predictor.
`timescale 1ns / 100ps

module tb_crc_checked_pcm16_unpack_core;

  localparam int QuietLimit = 1000;  // cycles with no transaction before giving up
  localparam int SettleGap  = 4;     // margin for the queue and output register after the last sample
  localparam int HoldCycles = 60;    // long receiver hold-off

  typedef logic [ccpu_pkg::ByteW-1:0] byte_t;
  typedef logic [ccpu_pkg::CrcW-1:0]  crc_t;
  typedef logic [ccpu_pkg::CfgDataW-1:0] cfg_data_t;

  // Expected sample, as it should leave the block
  typedef struct packed {
    logic [ccpu_pkg::SampleW-1:0] value;
    logic                         last;
    logic                         ok;
  } sample_due_t;

  // Tracks CRC, byte count and registers; holds the samples still due
  class pcm16_crc_tracker;
    crc_t                              crc_run;
    crc_t                              exp_crc;
    logic [ccpu_pkg::SampleTotalW-1:0] total;
    logic [31:0]                       byte_pos;
    byte_t                             low_hold;
    sample_due_t                       samples_due[$];
    int                                errors;

    function new();
      exp_crc = '0;
      total   = 1;
      errors  = 0;
      restart_load();
    endfunction

    function void restart_load();
      crc_run  = ccpu_pkg::CrcInit;
      byte_pos = '0;
      low_hold = '0;
    endfunction

    // Reflected CRC-32, folding the data in one bit at a time
    function crc_t crc8(crc_t c, byte_t b);
      crc_t r;
      r = c;
      for (int i = 0; i < ccpu_pkg::ByteW; i++) begin
        if (r[0] ^ b[i]) r = (r >> 1) ^ ccpu_pkg::CrcPoly;
        else r = r >> 1;
      end
      return r;
    endfunction

    function void set_reg(ccpu_pkg::cfg_reg_e idx, cfg_data_t v);
      case (idx)
        ccpu_pkg::CfgExpectedCrc: exp_crc = v;
        ccpu_pkg::CfgSampleTotal: total = v[ccpu_pkg::SampleTotalW-1:0];
        default: ;
      endcase
    endfunction

    // Bytes still needed to reach the last sample of the current load
    function longint unsigned bytes_left();
      longint unsigned done;
      longint unsigned need;
      done = byte_pos >> 1;
      need = (longint'(total) > done) ? longint'(total) - done : 1;
      return 2 * need - byte_pos[0];
    endfunction

    function longint unsigned load_bytes();
      return 2 * ((total == 0) ? 1 : longint'(total));
    endfunction

    // One byte transaction taken by the block
    function void take_byte(byte_t b);
      logic [31:0] done;
      sample_due_t e;
      crc_run = crc8(crc_run, b);
      if (!byte_pos[0]) begin
        low_hold = b;
        byte_pos++;
      end else begin
        done    = (byte_pos >> 1) + 1;
        e.value = {b, low_hold};
        e.last  = (done >= {1'b0, total});
        e.ok    = e.last && ((crc_run ^ ccpu_pkg::CrcInit) == exp_crc);
        samples_due.push_back(e);
        if (e.last) restart_load();
        else byte_pos++;
      end
    endfunction

    // One sample transaction delivered by the block
    function void check_sample(logic [ccpu_pkg::SampleW-1:0] v, logic last, logic ok);
      sample_due_t e;
      if (samples_due.size() == 0) begin
        $error("unexpected sample: value %0d is_last %0b crc_ok %0b", $signed(v), last, ok);
        errors++;
        return;
      end
      e = samples_due.pop_front();
      if (v !== e.value) begin
        $error("sample_value: expected %0d, got %0d", $signed(e.value), $signed(v));
        errors++;
      end
      if (last !== e.last) begin
        $error("is_last: expected %0b, got %0b", e.last, last);
        errors++;
      end
      if (ok !== e.ok) begin
        $error("crc_ok: expected %0b, got %0b", e.ok, ok);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [ccpu_pkg::CfgIdxW-1:0] cfg_idx_i;
  cfg_data_t                    cfg_wdata_i;

  ccpu_byte_if   byte_if ();
  ccpu_sample_if smp_if ();

  crc_checked_pcm16_unpack_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_i      (byte_if),
    .sample_o    (smp_if)
  );

  pcm16_crc_tracker tracker;
  int src_idle_pct;
  int snk_stall_pct;
  int bytes_sent;
  int quiet_cycles;
  int holdoff_left;
  bit holdoff_go;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Sample receiver: check each transaction, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (smp_if.valid && smp_if.ready) begin
        tracker.check_sample(smp_if.sample_value, smp_if.is_last, smp_if.crc_ok);
      end
      if (holdoff_go) begin
        holdoff_go   = 1'b0;
        holdoff_left = HoldCycles;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        smp_if.ready <= 1'b0;
      end else begin
        smp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((byte_if.valid && byte_if.ready) || (smp_if.valid && smp_if.ready)) begin
      quiet_cycles = 0;
    end else if (rst_ni) begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // One byte transaction, with random idle cycles ahead of it
  task automatic send_byte(input byte_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    do @(posedge clk_i); while (!byte_if.ready);
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_bytes(input byte_t q[$]);
    foreach (q[i]) send_byte(q[i]);
    byte_if.valid <= 1'b0;
  endtask

  // Wait until every sample is out and a trailing even byte has settled
  task automatic settle();
    while (tracker.samples_due.size() != 0) @(posedge clk_i);
    repeat (SettleGap) @(posedge clk_i);
  endtask

  task automatic write_reg(input ccpu_pkg::cfg_reg_e idx, input cfg_data_t v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  // Final CRC of the current load if it went on with these bytes
  function automatic crc_t crc_after(input byte_t q[$]);
    crc_t c;
    c = tracker.crc_run;
    foreach (q[i]) c = tracker.crc8(c, q[i]);
    return c ^ ccpu_pkg::CrcInit;
  endfunction

  // One random phase: set the registers, then send loads that match or not
  task automatic run_phase(input cfg_data_t total_w, input int n_loads,
                           input bit hold);
    byte_t           stim[$];
    byte_t           ref_q[$];
    byte_t           tmp[$];
    longint unsigned n;
    crc_t            expv;
    bit              full_ref;
    int              pick;
    int              at;
    settle();
    write_reg(ccpu_pkg::CfgSampleTotal, total_w);
    n = tracker.bytes_left();
    if (n > 64) begin
      // load too long to finish: plain stream with no last sample
      repeat (2 * n_loads) stim.push_back(byte_t'($urandom_range(255)));
      expv = $urandom();
    end else begin
      full_ref = (tracker.byte_pos == 0);
      repeat (n) ref_q.push_back(byte_t'($urandom_range(255)));
      expv = ($urandom_range(99) < 60) ? crc_after(ref_q) : $urandom();
      foreach (ref_q[i]) stim.push_back(ref_q[i]);
      for (int l = 1; l < n_loads; l++) begin
        pick = $urandom_range(9);
        tmp.delete();
        if (full_ref && pick < 6) begin
          foreach (ref_q[i]) tmp.push_back(ref_q[i]);
          // corrupted copy of the matching payload
          if (pick >= 4) begin
            at      = $urandom_range(tmp.size() - 1);
            tmp[at] = tmp[at] ^ (byte_t'(1) << $urandom_range(ccpu_pkg::ByteW - 1));
          end
        end else begin
          repeat (tracker.load_bytes()) tmp.push_back(byte_t'($urandom_range(255)));
        end
        foreach (tmp[i]) stim.push_back(tmp[i]);
      end
    end
    // partial load left over for the next phase
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) stim.push_back(byte_t'($urandom_range(255)));
    end
    write_reg(ccpu_pkg::CfgExpectedCrc, expv);
    if (hold) holdoff_go = 1'b1;
    send_bytes(stim);
  endtask

  // Stimulus
  initial begin
    byte_t     q[$];
    cfg_data_t tw;
    int        phase;
    int        r;
    int        n_loads;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    smp_if.ready      = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = ccpu_pkg::CfgExpectedCrc;
    cfg_wdata_i       = '0;
    src_idle_pct      = 0;
    snk_stall_pct     = 0;
    bytes_sent        = 0;
    quiet_cycles      = 0;
    holdoff_left      = 0;
    holdoff_go        = 1'b0;
    tracker           = new();
    rst_ni            = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: one sample, most negative value
    q = '{8'h00, 8'h80};
    send_bytes(q);

    // Three samples with extremes, matching CRC, top data bit set on the total write
    settle();
    write_reg(ccpu_pkg::CfgSampleTotal, 32'h8000_0003);
    q = '{8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF};
    write_reg(ccpu_pkg::CfgExpectedCrc, crc_after(q));
    send_bytes(q);

    // Zero total acts as one
    settle();
    write_reg(ccpu_pkg::CfgSampleTotal, '0);
    write_reg(ccpu_pkg::CfgExpectedCrc, 32'hFFFF_FFFF);
    q = '{8'h01, 8'h00};
    send_bytes(q);

    // Largest total, stop partway with a low byte held
    settle();
    write_reg(ccpu_pkg::CfgSampleTotal, 32'h7FFF_FFFF);
    write_reg(ccpu_pkg::CfgExpectedCrc, '0);
    q.delete();
    repeat (13) q.push_back(byte_t'($urandom_range(255)));
    send_bytes(q);

    // Total lowered below the count reached: next sample ends the load
    settle();
    write_reg(ccpu_pkg::CfgSampleTotal, 32'd2);
    q = '{8'h5A};
    write_reg(ccpu_pkg::CfgExpectedCrc, crc_after(q));
    send_bytes(q);

    // Random phases, idle pattern rotating through the modes
    phase = 0;
    while (bytes_sent < 720) begin
      case (phase % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 66; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 66; end
        default: begin src_idle_pct = 35; snk_stall_pct = 35; end
      endcase
      r = $urandom_range(99);
      if (r < 60) tw = $urandom_range(1, 8);
      else if (r < 70) tw = '0;
      else if (r < 85) tw = $urandom_range(9, 32);
      else if (r < 92) tw = 32'h7FFF_FFFF;
      else tw = $urandom();
      n_loads = (tw <= 8) ? $urandom_range(2, 6) : $urandom_range(1, 2);
      if (phase == 4) begin
        // long hold-off while the sender keeps offering
        tw      = 32'd4;
        n_loads = 6;
      end
      run_phase(tw, n_loads, phase == 4);
      phase++;
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.samples_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
